// ----- rtl/length_prefixed_frame_receiver_unit_macros.svh -----
// Assertion macros shared by the frame receiver RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_UNIT_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication.
`define LPFR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame receiver check failed");

// Next-cycle implication.
`define LPFR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame receiver check failed");

`endif

// ----- rtl/lpfr_pkg.sv -----
// Package for the length-prefixed frame receiver: codes, widths and shared types.
// No dependencies.
package lpfr_pkg;

    localparam int CMD_W        = 2;
    localparam int BYTE_W       = 8;
    localparam int STATUS_W     = 3;
    localparam int OUT_IDX_W    = 12;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int MAX_BODY_W   = 13;
    localparam int HCNT_W       = 4;
    localparam int HEADER_BYTES = 9;
    localparam int LEN_FIRST    = 5;
    localparam int LEN_ADJUST   = 4;

    localparam logic [BYTE_W-1:0]     MARKER_RESET   = 8'h5e;
    localparam logic [MAX_BODY_W-1:0] MAX_BODY_RESET = 13'd4096;

    // Input commands.
    localparam logic [CMD_W-1:0] CMD_DATA     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLOSE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LINK_ERR = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_PROGRESS = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_CLOSED   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_ERROR    = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_COMPLETE = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_SIZE_ERR = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BODY     = 2'd1;

    typedef enum logic [1:0] {
        OP_DATA     = 2'd0,
        OP_CLOSE    = 2'd1,
        OP_LINK_ERR = 2'd2,
        OP_IDLE     = 2'd3
    } lpfr_op_kind_t;

    typedef struct packed {
        lpfr_op_kind_t     kind;
        logic [BYTE_W-1:0] data;
    } lpfr_op_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic                 body_valid;
        logic [BYTE_W-1:0]    body_byte;
        logic [OUT_IDX_W-1:0] body_index;
        logic [OUT_IDX_W-1:0] frame_length;
    } lpfr_result_t;

endpackage

// ----- rtl/lpfr_ifs.sv -----
// Channel interfaces of the frame receiver: byte input, result output, configuration.
// Depends on lpfr_pkg.
interface lpfr_in_if;
    import lpfr_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data_byte;
    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface lpfr_out_if;
    import lpfr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic                 body_valid;
    logic [BYTE_W-1:0]    body_byte;
    logic [OUT_IDX_W-1:0] body_index;
    logic [OUT_IDX_W-1:0] frame_length;
    modport source (output valid, output status, output body_valid, output body_byte,
                    output body_index, output frame_length, input ready);
    modport sink (input valid, input status, input body_valid, input body_byte,
                  input body_index, input frame_length, output ready);
endinterface

interface lpfr_cfg_if;
    import lpfr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/lpfr_queue.sv -----
// Small first-in first-out queue of classified input operations.
// Depends on lpfr_pkg.
module lpfr_queue #(
    parameter int DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lpfr_pkg::lpfr_op_t push_op,
    output logic               full,
    input  logic               pop,
    output lpfr_pkg::lpfr_op_t pop_op,
    output logic               not_empty
);
    import lpfr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    lpfr_op_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_op    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ----- rtl/lpfr_front.sv -----
// Front end: accepts input items and classifies each command into a queue operation.
// Depends on lpfr_pkg and lpfr_ifs.
module lpfr_front (
    lpfr_in_if.sink            frame_in,
    input  logic               queue_full,
    output logic               push,
    output lpfr_pkg::lpfr_op_t push_op
);
    import lpfr_pkg::*;

    assign frame_in.ready = !queue_full;
    assign push           = frame_in.valid && !queue_full;

    always_comb
    begin
        push_op.data = frame_in.data_byte;
        case (frame_in.cmd)
            CMD_DATA:     push_op.kind = OP_DATA;
            CMD_CLOSE:    push_op.kind = OP_CLOSE;
            CMD_LINK_ERR: push_op.kind = OP_LINK_ERR;
            default:      push_op.kind = OP_IDLE;
        endcase
    end

endmodule

// ----- rtl/lpfr_back.sv -----
// Back end: header hunting, length check and body tracking, plus the result register.
// Depends on lpfr_pkg, lpfr_ifs and the assertion macro header.
`include "length_prefixed_frame_receiver_unit_macros.svh"

module lpfr_back #(
    parameter int BODY_LIMIT = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op_valid,
    input  lpfr_pkg::lpfr_op_t op,
    output logic               pop,
    lpfr_cfg_if.sink           cfg,
    lpfr_out_if.source         result_out
);
    import lpfr_pkg::*;

    localparam int CNT_W = $clog2(BODY_LIMIT);
    localparam int EXT_W = (CNT_W > OUT_IDX_W) ? CNT_W : OUT_IDX_W;

    typedef enum logic [2:0] {
        ST_HUNT   = 3'b001,
        ST_HEADER = 3'b010,
        ST_BODY   = 3'b100
    } lpfr_state_t;

    lpfr_state_t           state_reg, state_next;
    logic [HCNT_W-1:0]     hcount_reg, hcount_next;
    logic [23:0]           len_lo_reg, len_lo_next;
    logic [CNT_W-1:0]      expected_reg, expected_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [BYTE_W-1:0]     marker_reg;
    logic [MAX_BODY_W-1:0] max_body_reg;
    logic                  out_valid_reg, out_valid_next;
    lpfr_result_t          result_reg, result_next;

    logic [31:0]      len_word;
    logic [32:0]      len_sum;
    logic [CNT_W-1:0] count_inc;
    logic [CNT_W-1:0] new_expected;
    logic [EXT_W-1:0] expected_ext;
    logic [EXT_W-1:0] new_expected_ext;
    logic [EXT_W-1:0] count_ext;
    logic             size_bad;

    assign cfg.ready = 1'b1;
    assign pop       = op_valid && (!out_valid_reg || result_out.ready);

    // The length field is signed; the adjusted length is checked in 33 bits.
    assign len_word         = {op.data, len_lo_reg};
    assign len_sum          = {len_word[31], len_word} + 33'(LEN_ADJUST);
    assign size_bad         = len_sum[32]
                              || (len_sum[31:0] >= 32'(max_body_reg))
                              || (len_sum[31:0] >= 32'(BODY_LIMIT));
    assign new_expected     = len_sum[CNT_W-1:0];
    assign count_inc        = count_reg + 1'b1;
    assign expected_ext     = EXT_W'(expected_reg);
    assign new_expected_ext = EXT_W'(new_expected);
    assign count_ext        = EXT_W'(count_reg);

    always_comb
    begin
        state_next    = state_reg;
        hcount_next   = hcount_reg;
        len_lo_next   = len_lo_reg;
        expected_next = expected_reg;
        count_next    = count_reg;
        result_next   = '0;
        result_next.status = STATUS_PROGRESS;
        if (pop)
        begin
            case (op.kind)
                OP_CLOSE, OP_LINK_ERR:
                begin
                    result_next.status = (op.kind == OP_CLOSE) ? STATUS_CLOSED : STATUS_ERROR;
                    if (state_reg == ST_BODY)
                    begin
                        result_next.frame_length = expected_ext[OUT_IDX_W-1:0];
                    end
                    state_next  = ST_HUNT;
                    hcount_next = '0;
                end
                OP_DATA:
                begin
                    case (state_reg)
                        ST_BODY:
                        begin
                            result_next.body_valid   = 1'b1;
                            result_next.body_byte    = op.data;
                            result_next.body_index   = count_ext[OUT_IDX_W-1:0];
                            result_next.frame_length = expected_ext[OUT_IDX_W-1:0];
                            count_next               = count_inc;
                            if (count_inc >= expected_reg)
                            begin
                                result_next.status = STATUS_COMPLETE;
                                state_next         = ST_HUNT;
                                hcount_next        = '0;
                            end
                        end
                        ST_HUNT:
                        begin
                            if (op.data != marker_reg)
                            begin
                                result_next.status = STATUS_ERROR;
                            end
                            else
                            begin
                                state_next  = ST_HEADER;
                                hcount_next = HCNT_W'(1);
                            end
                        end
                        ST_HEADER:
                        begin
                            hcount_next = hcount_reg + 1'b1;
                            // Bytes 5 to 7 shift in from the top so byte 5 ends up lowest.
                            if (hcount_reg >= HCNT_W'(LEN_FIRST)
                                && hcount_reg < HCNT_W'(HEADER_BYTES - 1))
                            begin
                                len_lo_next = {op.data, len_lo_reg[23:8]};
                            end
                            if (hcount_reg == HCNT_W'(HEADER_BYTES - 1))
                            begin
                                hcount_next = '0;
                                if (size_bad)
                                begin
                                    result_next.status = STATUS_SIZE_ERR;
                                    state_next         = ST_HUNT;
                                end
                                else
                                begin
                                    expected_next            = new_expected;
                                    count_next               = '0;
                                    result_next.frame_length =
                                        new_expected_ext[OUT_IDX_W-1:0];
                                    if (new_expected == '0)
                                    begin
                                        result_next.status = STATUS_COMPLETE;
                                        state_next         = ST_HUNT;
                                    end
                                    else
                                    begin
                                        state_next = ST_BODY;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            state_next  = ST_HUNT;
                            hcount_next = '0;
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_HUNT;
            hcount_reg    <= '0;
            len_lo_reg    <= '0;
            expected_reg  <= '0;
            count_reg     <= '0;
            marker_reg    <= MARKER_RESET;
            max_body_reg  <= MAX_BODY_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hcount_reg    <= hcount_next;
            len_lo_reg    <= len_lo_next;
            expected_reg  <= expected_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_START_MARKER: marker_reg   <= cfg.data[BYTE_W-1:0];
                    CFG_MAX_BODY:     max_body_reg <= cfg.data[MAX_BODY_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= result_next;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.status       = result_reg.status;
    assign result_out.body_valid   = result_reg.body_valid;
    assign result_out.body_byte    = result_reg.body_byte;
    assign result_out.body_index   = result_reg.body_index;
    assign result_out.frame_length = result_reg.frame_length;

    `LPFR_ASSERT_IMP(a_body_count_below_length, state_reg == ST_BODY, count_reg < expected_reg)
    `LPFR_ASSERT_IMP(a_header_count_range, state_reg == ST_HEADER,
                     hcount_reg >= HCNT_W'(1) && hcount_reg < HCNT_W'(HEADER_BYTES))
    `LPFR_ASSERT_IMP(a_hunt_count_clear, state_reg == ST_HUNT, hcount_reg == '0)
    `LPFR_ASSERT_NXT(a_pop_gives_result, pop, out_valid_reg)

endmodule

// ----- rtl/length_prefixed_frame_receiver_unit.sv -----
// Length-prefixed frame receiver top level: front end, operation queue, back end.
// Throughput is one byte or event per cycle while result_out is not stalled; every accepted
// item yields exactly one result. A result is offered after its item passes the queue register
// and then the result register of the back end.
// Reset (rst_n, asynchronous, active low) empties the queue and the result register,
// sets header hunting and loads start_marker 0x5e and max_body 4096.
module length_prefixed_frame_receiver_unit #(
    parameter int BODY_LIMIT  = 4096,
    parameter int QUEUE_DEPTH = 2
) (
    input logic        clk,
    input logic        rst_n,
    lpfr_in_if.sink    frame_in,
    lpfr_out_if.source result_out,
    lpfr_cfg_if.sink   cfg
);
    import lpfr_pkg::*;

    logic     queue_full;
    logic     push;
    lpfr_op_t push_op;
    logic     pop;
    lpfr_op_t pop_op;
    logic     op_valid;

    lpfr_front u_front (
        .frame_in   (frame_in),
        .queue_full (queue_full),
        .push       (push),
        .push_op    (push_op)
    );

    lpfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .full      (queue_full),
        .pop       (pop),
        .pop_op    (pop_op),
        .not_empty (op_valid)
    );

    lpfr_back #(
        .BODY_LIMIT (BODY_LIMIT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (op_valid),
        .op         (pop_op),
        .pop        (pop),
        .cfg        (cfg),
        .result_out (result_out)
    );

endmodule

// ----- verif/length_prefixed_frame_receiver_unit_tb.sv -----
// Self-checking testbench for the length-prefixed frame receiver: a directed table, then
// random frames under several register settings and idle patterns, checked by a predictor.
// Depends on lpfr_pkg, the lpfr channel interfaces and length_prefixed_frame_receiver_unit.
module length_prefixed_frame_receiver_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpfr_pkg::*;

    localparam int BODY_LIMIT      = 4096;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int NUM_DIRECTED    = 24;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int PRINT_CAP       = 40;

    // Index with no register behind it; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        lpfr_op_kind_t       kind;
        logic [BYTE_W-1:0]   data;
        logic                typed;
        logic [STATUS_W-1:0] status;
    } directed_row_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] marker;
        logic [CFG_DATA_W-1:0] max_body;
        logic [6:0]            send_idle;
        logic [6:0]            recv_stall;
    } phase_cfg_t;

    logic clk = 1'b0;
    logic rst_n;

    lpfr_in_if  frame_in ();
    lpfr_out_if result_out ();
    lpfr_cfg_if cfg ();

    length_prefixed_frame_receiver_unit #(.BODY_LIMIT(BODY_LIMIT)) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_in   (frame_in),
        .result_out (result_out),
        .cfg        (cfg)
    );

    always #1 clk = ~clk;

    // Predictor state and its copy of the registers.
    logic [BYTE_W-1:0]     cur_marker;
    logic [MAX_BODY_W-1:0] cur_max_body;
    logic                  rx_in_body;
    logic [HCNT_W-1:0]     hdr_count;
    logic [31:0]           len_word;
    logic [OUT_IDX_W-1:0]  body_len;
    logic [OUT_IDX_W-1:0]  body_pos;

    lpfr_result_t exp_results [$];
    lpfr_op_t     tx_plan [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int results_seen   = 0;
    int frames_done    = 0;
    int size_errors    = 0;
    int items_sent     = 0;
    int cycle_count    = 0;

    // Expected status is typed in only where it is plain from the header bytes.
    directed_row_t directed_rows [NUM_DIRECTED] = '{
        '{OP_IDLE,     8'hff, 1'b1, STATUS_PROGRESS},
        '{OP_DATA,     8'h00, 1'b1, STATUS_ERROR},
        '{OP_DATA,     8'hff, 1'b1, STATUS_ERROR},
        '{OP_CLOSE,    8'h00, 1'b1, STATUS_CLOSED},
        '{OP_DATA,     8'h5e, 1'b0, STATUS_PROGRESS},
        '{OP_LINK_ERR, 8'hff, 1'b1, STATUS_ERROR},
        // Length word of minus four: empty body, done on the last header byte.
        '{OP_DATA,     8'h5e, 1'b0, STATUS_PROGRESS},
        '{OP_DATA,     8'h00, 1'b0, STATUS_PROGRESS},
        '{OP_DATA,     8'hff, 1'b0, STATUS_PROGRESS},
        '{OP_DATA,     8'h00, 1'b0, STATUS_PROGRESS},
        '{OP_DATA,     8'hff, 1'b0, STATUS_PROGRESS},
        '{OP_DATA,     8'hfc, 1'b0, STATUS_PROGRESS},
        '{OP_DATA,     8'hff, 1'b0, STATUS_PROGRESS},
        '{OP_DATA,     8'hff, 1'b0, STATUS_PROGRESS},
        '{OP_DATA,     8'hff, 1'b1, STATUS_COMPLETE},
        // Most negative length word: size error.
        '{OP_DATA,     8'h5e, 1'b0, STATUS_PROGRESS},
        '{OP_DATA,     8'ha5, 1'b0, STATUS_PROGRESS},
        '{OP_DATA,     8'h5a, 1'b0, STATUS_PROGRESS},
        '{OP_DATA,     8'h00, 1'b0, STATUS_PROGRESS},
        '{OP_DATA,     8'h00, 1'b0, STATUS_PROGRESS},
        '{OP_DATA,     8'h00, 1'b0, STATUS_PROGRESS},
        '{OP_DATA,     8'h00, 1'b0, STATUS_PROGRESS},
        '{OP_DATA,     8'h00, 1'b0, STATUS_PROGRESS},
        '{OP_DATA,     8'h80, 1'b1, STATUS_SIZE_ERR}
    };

    phase_cfg_t phase_plan [NUM_PHASES] = '{
        '{13'h005e, 13'd4096, 7'd0,  7'd0},
        '{13'h0000, 13'd1,    7'd52, 7'd0},
        '{13'h00ff, 13'd0,    7'd0,  7'd52},
        '{13'h1fa5, 13'd8191, 7'd32, 7'd32},
        '{13'h003c, 13'd16,   7'd0,  7'd0},
        '{13'h005e, 13'd300,  7'd52, 7'd0},
        '{13'h0080, 13'd4095, 7'd0,  7'd52},
        '{13'h0017, 13'd2,    7'd32, 7'd32}
    };

    function automatic lpfr_result_t predict_step(input lpfr_op_t op);
        lpfr_result_t r;
        longint       sz;
        r = '0;
        case (op.kind)
            OP_CLOSE, OP_LINK_ERR:
            begin
                r.status = (op.kind == OP_CLOSE) ? STATUS_CLOSED : STATUS_ERROR;
                if (rx_in_body)
                    r.frame_length = body_len;
                rx_in_body = 1'b0;
                hdr_count  = '0;
            end
            OP_DATA:
            begin
                if (rx_in_body)
                begin
                    r.body_valid   = 1'b1;
                    r.body_byte    = op.data;
                    r.body_index   = body_pos;
                    r.frame_length = body_len;
                    body_pos++;
                    if (body_pos >= body_len)
                    begin
                        r.status   = STATUS_COMPLETE;
                        rx_in_body = 1'b0;
                        hdr_count  = '0;
                    end
                end
                else if (hdr_count == 0 && op.data != cur_marker)
                begin
                    r.status = STATUS_ERROR;
                end
                else
                begin
                    if (hdr_count == 0)
                        len_word = '0;
                    if (hdr_count >= LEN_FIRST && hdr_count < LEN_FIRST + 4)
                        len_word |= 32'(op.data) << (8 * (hdr_count - LEN_FIRST));
                    hdr_count++;
                    if (hdr_count >= HEADER_BYTES)
                    begin
                        sz = longint'($signed(len_word)) + LEN_ADJUST;
                        if (sz < 0 || sz >= longint'(cur_max_body) || sz >= BODY_LIMIT)
                        begin
                            r.status  = STATUS_SIZE_ERR;
                            hdr_count = '0;
                        end
                        else
                        begin
                            body_len       = sz[OUT_IDX_W-1:0];
                            body_pos       = '0;
                            r.frame_length = body_len;
                            hdr_count      = '0;
                            if (body_len == 0)
                                r.status = STATUS_COMPLETE;
                            else
                                rx_in_body = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] result %0d mismatch: %s", $realtime, results_seen, what);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task automatic send_op(input lpfr_op_t op, input logic typed,
                           input logic [STATUS_W-1:0] typed_status);
        lpfr_result_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            frame_in.valid <= 1'b0;
            @(posedge clk);
        end
        frame_in.valid     <= 1'b1;
        frame_in.cmd       <= op.kind;
        frame_in.data_byte <= op.data;
        @(posedge clk);
        while (!frame_in.ready)
            @(posedge clk);
        want = predict_step(op);
        if (typed)
        begin
            want        = '0;
            want.status = typed_status;
        end
        exp_results.push_back(want);
        items_sent++;
    endtask

    // Leaves valid high so back-to-back writes follow without a gap; the caller lowers it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        if (idx == CFG_START_MARKER)
            cur_marker = value[BYTE_W-1:0];
        else if (idx == CFG_MAX_BODY)
            cur_max_body = value[MAX_BODY_W-1:0];
    endtask

    task automatic drain_results();
        frame_in.valid <= 1'b0;
        while (exp_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic push_op(input lpfr_op_kind_t kind, input logic [BYTE_W-1:0] data);
        lpfr_op_t op;
        op.kind = kind;
        op.data = data;
        tx_plan.push_back(op);
    endtask

    task automatic plan_header(input logic [31:0] word);
        push_op(OP_DATA, cur_marker);
        repeat (4)
            push_op(OP_DATA, 8'($urandom));
        for (int k = 0; k < 4; k++)
            push_op(OP_DATA, word[8*k +: 8]);
    endtask

    // A well-formed frame; a non-negative cut_at breaks it off with a close or link error.
    task automatic plan_frame(input int body_n, input int cut_at);
        int start;
        start = tx_plan.size();
        plan_header(32'(body_n) - 32'd4);
        for (int k = 0; k < body_n; k++)
            push_op(OP_DATA, 8'($urandom));
        if (cut_at >= 0)
        begin
            while (tx_plan.size() > start + cut_at)
                void'(tx_plan.pop_back());
            push_op($urandom_range(1) ? OP_CLOSE : OP_LINK_ERR, 8'($urandom));
        end
    endtask

    task automatic plan_random_piece();
        int cap;
        int lim;
        int pick;
        int body_n;
        logic [31:0] word;
        cap  = (int'(cur_max_body) < BODY_LIMIT) ? int'(cur_max_body) : BODY_LIMIT;
        lim  = (cap > 0) ? cap - 1 : 0;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            plan_frame($urandom_range(lim < 24 ? lim : 24), -1);
        end
        else if (pick < 62)
        begin
            plan_frame($urandom_range(lim < 300 ? lim : 300), -1);
        end
        else if (pick < 70)
        begin
            // Largest allowed body or one past it when the cap is at most 300, else up to 300 bytes.
            if (cap <= 300)
                plan_frame(cap - 1 + int'($urandom_range(1)), -1);
            else
                plan_frame($urandom_range(300), -1);
        end
        else if (pick < 80)
        begin
            case ($urandom_range(3))
                0: word = 32'h8000_0000 | $urandom;
                1: word = 32'(cap) + $urandom_range(3) - 32'd4;
                2: word = 32'h7fff_ffff;
                default: word = 32'hffff_fffb;
            endcase
            plan_header(word);
        end
        else if (pick < 90)
        begin
            body_n = $urandom_range(lim < 24 ? lim : 24);
            plan_frame(body_n, $urandom_range(HEADER_BYTES - 1 + body_n));
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                push_op(lpfr_op_kind_t'($urandom_range(3)), 8'($urandom));
        end
    endtask

    always @(posedge clk)
        result_out.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin : result_check
        lpfr_result_t want;
        if (rst_n && result_out.valid === 1'b1 && result_out.ready === 1'b1)
        begin
            results_seen++;
            if (exp_results.size() == 0)
            begin
                report_mismatch("result with no request outstanding");
            end
            else
            begin
                want = exp_results.pop_front();
                check_field("status", 16'(result_out.status), 16'(want.status));
                check_field("body_valid", 16'(result_out.body_valid), 16'(want.body_valid));
                check_field("body_byte", 16'(result_out.body_byte), 16'(want.body_byte));
                check_field("body_index", 16'(result_out.body_index), 16'(want.body_index));
                check_field("frame_length", 16'(result_out.frame_length),
                            16'(want.frame_length));
                if (want.status == STATUS_COMPLETE)
                    frames_done++;
                if (want.status == STATUS_SIZE_ERR)
                    size_errors++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("length_prefixed_frame_receiver_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        phase_cfg_t ps;
        lpfr_op_t   op;
        int         phase_items;

        rst_n               = 1'b0;
        frame_in.valid      = 1'b0;
        frame_in.cmd        = CMD_DATA;
        frame_in.data_byte  = '0;
        result_out.ready    = 1'b0;
        cfg.valid           = 1'b0;
        cfg.index           = CFG_START_MARKER;
        cfg.data            = '0;
        cur_marker          = MARKER_RESET;
        cur_max_body        = MAX_BODY_RESET;
        rx_in_body          = 1'b0;
        hdr_count           = '0;
        len_word            = '0;
        body_len            = '0;
        body_pos            = '0;

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            op.kind = directed_rows[i].kind;
            op.data = directed_rows[i].data;
            send_op(op, directed_rows[i].typed, directed_rows[i].status);
        end
        drain_results();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            ps = phase_plan[p];
            write_reg(CFG_START_MARKER, ps.marker);
            write_reg(CFG_MAX_BODY, ps.max_body);
            if (p == 2)
                write_reg(CFG_UNUSED, 13'h1abc);
            cfg.valid <= 1'b0;
            send_idle_pct  = ps.send_idle;
            recv_stall_pct = ps.recv_stall;

            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
            begin
                plan_random_piece();
                while (tx_plan.size() > 0)
                begin
                    op = tx_plan.pop_front();
                    send_op(op, 1'b0, STATUS_PROGRESS);
                    if (op.kind != OP_IDLE)
                        phase_items++;
                end
            end
            drain_results();
        end

        repeat (8)
            @(posedge clk);

        $display("Sent %0d requests over %0d register settings; checked %0d results.",
                 items_sent, NUM_PHASES, results_seen);
        $display("Frames completed: %0d, size errors seen: %0d, mismatches: %0d.",
                 frames_done, size_errors, mismatches);
        if (mismatches == 0)
            $display("length_prefixed_frame_receiver_unit verification clean");
        else
            $display("length_prefixed_frame_receiver_unit verification failed");
        $finish;
    end

endmodule
